// ===== rtl/pse_pkg.sv =====
// Shared types and constants of the printable string extractor.
`default_nettype none

package pse_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 40;
   localparam int BASE_BITS      = 40;
   localparam int RUN_BITS       = 32;
   localparam int LEN_BITS       = 32;
   localparam int COUNT_BITS     = 17;
   localparam int LENGTH_BITS    = 16;

   localparam logic [7:0]            CHAR_LOW           = 8'h20;
   localparam logic [7:0]            CHAR_END           = 8'h80;
   localparam logic [RUN_BITS-1:0]   MIN_RUN_CHARS      = 32'd4;
   localparam logic [LENGTH_BITS-1:0] MIN_LENGTH_RESET  = 16'd5;
   localparam logic [LENGTH_BITS-1:0] REPORT_LIMIT_RESET = 16'd10000;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODE         = 3'd0,
      CSR_BIG_ENDIAN   = 3'd1,
      CSR_MIN_LENGTH   = 3'd2,
      CSR_REPORT_LIMIT = 3'd3,
      CSR_BASE_OFFSET  = 3'd4
   } pse_csr_index_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_EXTEND = 2'd1,
      EV_CLOSE  = 2'd2
   } pse_ev_kind_type;

   typedef struct packed {
      pse_ev_kind_type kind;
      logic            last;
   } pse_event_type;

   typedef struct packed {
      logic                   mode;
      logic                   big_endian;
      logic [LENGTH_BITS-1:0] min_length;
      logic [LENGTH_BITS-1:0] report_limit;
   } pse_cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } pse_queue_status_type;

   function automatic logic is_printable(input logic [7:0] b);
      return (b >= CHAR_LOW) && (b < CHAR_END);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pse_front.sv =====
// Front end: byte intake, UTF-16 pairing and character classification.
`default_nettype none

module pse_front #(
   parameter int OFFSET_BITS = 40
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire pse_pkg::pse_cfg_type       cfg,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [7:0]                 req_data_byte,
   input  wire logic                       req_last,
   input  wire pse_pkg::pse_queue_status_type q_status,
   output logic                            push,
   output pse_pkg::pse_event_type          push_event,
   output logic [OFFSET_BITS-1:0]          push_start
);
   import pse_pkg::*;

   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [7:0]             held_byte_ff, held_byte_in;
   logic                   held_valid_ff, held_valid_in;
   logic [7:0]             unit_hi, unit_lo;

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      pos_in          = (pos_ff != '1) ? pos_ff + OFFSET_BITS'(1) : pos_ff;
      held_byte_in    = held_byte_ff;
      held_valid_in   = held_valid_ff;
      push_event.kind = EV_NONE;
      push_event.last = req_last;
      push_start      = pos_ff;
      unit_hi = cfg.big_endian ? held_byte_ff : req_data_byte;
      unit_lo = cfg.big_endian ? req_data_byte : held_byte_ff;
      if (!cfg.mode) begin
         held_valid_in   = 1'b0;
         push_event.kind = is_printable(req_data_byte) ? EV_EXTEND : EV_CLOSE;
      end else if (held_valid_ff) begin
         if (unit_hi == 8'h00 && is_printable(unit_lo)) begin
            // unit began on the previous byte
            push_event.kind = EV_EXTEND;
            push_start      = (pos_ff == '0) ? pos_ff : pos_ff - OFFSET_BITS'(1);
            held_valid_in   = 1'b0;
         end else begin
            // slide the window on by one byte
            push_event.kind = EV_CLOSE;
            held_byte_in    = req_data_byte;
         end
      end else begin
         held_byte_in  = req_data_byte;
         held_valid_in = 1'b1;
      end
      if (req_last) begin
         pos_in        = '0;
         held_byte_in  = '0;
         held_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         held_valid_ff <= 1'b0;
      end else if (push) begin
         pos_ff        <= pos_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         held_byte_ff <= held_byte_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pse_queue.sv =====
// Two-entry queue between the front end and the run tracker.
`default_nettype none

module pse_queue #(
   parameter int DATA_BITS = 43
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [DATA_BITS-1:0]  push_data,
   input  wire logic                  pop,
   output logic [DATA_BITS-1:0]       pop_data,
   output pse_pkg::pse_queue_status_type status
);
   import pse_pkg::*;

   localparam int Depth = 2;

   logic [DATA_BITS-1:0] mem_ff [Depth];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 do_push, do_pop;

   assign status.full  = (count_ff == 2'(Depth));
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pse_back.sv =====
// Back end: run tracking, report decision and the result register.
`default_nettype none

module pse_back #(
   parameter int OFFSET_BITS = 40
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire pse_pkg::pse_cfg_type       cfg,
   input  wire logic [OFFSET_BITS-1:0]     base_offset,
   input  wire pse_pkg::pse_queue_status_type q_status,
   output logic                            pop,
   input  wire pse_pkg::pse_event_type     pop_event,
   input  wire logic [OFFSET_BITS-1:0]     pop_start,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [OFFSET_BITS-1:0]          rsp_start_offset,
   output logic [pse_pkg::LEN_BITS-1:0]    rsp_length_bytes,
   output logic                            rsp_limit_reached
);
   import pse_pkg::*;

   logic [RUN_BITS-1:0]    run_chars_ff, run_chars_in, run_ext;
   logic [OFFSET_BITS-1:0] run_start_ff, run_start_in, start_ext;
   logic [COUNT_BITS-1:0]  count_ff, count_in, count_inc;
   logic                   silenced_ff, silenced_in;
   logic                   do_close, hit, flag;
   logic [LEN_BITS-1:0]    len;

   logic                   valid_ff, valid_in;
   logic [OFFSET_BITS-1:0] start_offset_ff, start_offset_in;
   logic [LEN_BITS-1:0]    length_ff, length_in;
   logic                   limit_ff, limit_in;

   assign pop = !q_status.empty && (!valid_ff || rsp_ready);

   always_comb begin
      run_ext   = run_chars_ff;
      start_ext = run_start_ff;
      if (pop_event.kind == EV_EXTEND) begin
         if (run_chars_ff == '0) begin
            start_ext = pop_start;
         end
         if (run_chars_ff != '1) begin
            run_ext = run_chars_ff + RUN_BITS'(1);
         end
      end
      do_close = (pop_event.kind == EV_CLOSE) || pop_event.last;
      hit = do_close && (run_ext > MIN_RUN_CHARS)
            && (run_ext >= RUN_BITS'(cfg.min_length)) && !silenced_ff;
      count_inc = (count_ff != '1) ? count_ff + COUNT_BITS'(1) : count_ff;
      flag      = count_inc > COUNT_BITS'(cfg.report_limit);
      if (!cfg.mode) begin
         len = run_ext;
      end else begin
         len = run_ext[RUN_BITS-1] ? '1 : {run_ext[RUN_BITS-2:0], 1'b0};
      end

      run_chars_in = do_close ? '0 : run_ext;
      run_start_in = start_ext;
      count_in     = hit ? count_inc : count_ff;
      silenced_in  = silenced_ff || (hit && flag);
      if (pop_event.last) begin
         run_start_in = '0;
         count_in     = '0;
         silenced_in  = 1'b0;
      end

      valid_in        = (valid_ff && !rsp_ready) || (pop && hit);
      start_offset_in = start_ext + base_offset;
      length_in       = len;
      limit_in        = flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_chars_ff <= '0;
         run_start_ff <= '0;
         count_ff     <= '0;
         silenced_ff  <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         if (pop) begin
            run_chars_ff <= run_chars_in;
            run_start_ff <= run_start_in;
            count_ff     <= count_in;
            silenced_ff  <= silenced_in;
         end
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && hit) begin
         start_offset_ff <= start_offset_in;
         length_ff       <= length_in;
         limit_ff        <= limit_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_start_offset  = start_offset_ff;
   assign rsp_length_bytes  = length_ff;
   assign rsp_limit_reached = limit_ff;

endmodule

`default_nettype wire

// ===== rtl/printable_string_extractor.sv =====
// Printable string extractor: reports runs of printable ASCII or UTF-16 text in a byte stream.
//
// Bytes of the image arrive on the req_ channel, one per transfer, with
// req_last on the final byte. Each run of more than four characters that
// also meets min_length is reported on the rsp_ channel as its start offset
// plus base_offset, its length in bytes and the limit flag.
// Throughput is one byte per clock while req_ready is high. A report appears
// on rsp_valid once the byte that ends the run has passed the queue: the
// front end classifies the byte as it arrives and writes it to the queue at
// the transfer, and the run tracker loads the result register once it is free.
// A two-entry queue separates the two, so the front end keeps taking bytes
// while a result waits; once the queue and result register are both full,
// req_ready drops until rsp_ready takes the result.
// Registers must be written through csr_we/csr_index/csr_wdata only while no
// byte is in flight; the block does not enforce this. Reset restores the register
// defaults (byte mode, little endian, min_length 5, report_limit 10000, base_offset
// 0) and clears the scan state, which also clears itself after each byte marked last.
`default_nettype none

module printable_string_extractor #(
   parameter int OFFSET_BITS = 40
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [pse_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [pse_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [7:0]                           req_data_byte,
   input  wire logic                                 req_last,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [OFFSET_BITS-1:0]                    rsp_start_offset,
   output logic [pse_pkg::LEN_BITS-1:0]              rsp_length_bytes,
   output logic                                      rsp_limit_reached
);
   import pse_pkg::*;

   localparam int BaseKeep  = (OFFSET_BITS < BASE_BITS) ? OFFSET_BITS : BASE_BITS;
   localparam int QueueBits = OFFSET_BITS + $bits(pse_event_type);

   pse_cfg_type            cfg_ff;
   logic [OFFSET_BITS-1:0] base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= 1'b0;
         cfg_ff.big_endian   <= 1'b0;
         cfg_ff.min_length   <= MIN_LENGTH_RESET;
         cfg_ff.report_limit <= REPORT_LIMIT_RESET;
         base_ff             <= '0;
      end else if (csr_we) begin
         case (pse_csr_index_type'(csr_index))
            CSR_MODE:         cfg_ff.mode         <= csr_wdata[0];
            CSR_BIG_ENDIAN:   cfg_ff.big_endian   <= csr_wdata[0];
            CSR_MIN_LENGTH:   cfg_ff.min_length   <= csr_wdata[LENGTH_BITS-1:0];
            CSR_REPORT_LIMIT: cfg_ff.report_limit <= csr_wdata[LENGTH_BITS-1:0];
            CSR_BASE_OFFSET:  base_ff <= OFFSET_BITS'(csr_wdata[BaseKeep-1:0]);
            default: ;
         endcase
      end
   end

   pse_queue_status_type   q_status;
   logic                   push, pop;
   pse_event_type          push_event, pop_event;
   logic [OFFSET_BITS-1:0] push_start, pop_start;
   logic [QueueBits-1:0]   pop_data;

   pse_front #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data_byte(req_data_byte),
      .req_last     (req_last),
      .q_status     (q_status),
      .push         (push),
      .push_event   (push_event),
      .push_start   (push_start)
   );

   pse_queue #(
      .DATA_BITS(QueueBits)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data({push_start, push_event}),
      .pop      (pop),
      .pop_data (pop_data),
      .status   (q_status)
   );

   assign pop_event = pse_event_type'(pop_data[$bits(pse_event_type)-1:0]);
   assign pop_start = pop_data[QueueBits-1:$bits(pse_event_type)];

   pse_back #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .base_offset      (base_ff),
      .q_status         (q_status),
      .pop              (pop),
      .pop_event        (pop_event),
      .pop_start        (pop_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_start_offset (rsp_start_offset),
      .rsp_length_bytes (rsp_length_bytes),
      .rsp_limit_reached(rsp_limit_reached)
   );

   // a report always covers more than four characters
   a_len_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_length_bytes > LEN_BITS'(MIN_RUN_CHARS)))
      else $error("report shorter than five bytes");

   // UTF-16 reports are whole units unless saturated
   a_len_even: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && cfg_ff.mode) |->
         (!rsp_length_bytes[0] || rsp_length_bytes == '1))
      else $error("odd UTF-16 report length");

   // the tracker only takes from a non-empty queue, into a free result register
   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!q_status.empty && (!rsp_valid || rsp_ready)))
      else $error("pop from empty queue or onto a held result");

   // queue cannot be both full and empty
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue status inconsistent");

endmodule

`default_nettype wire
